// ===== rtl/core/dcd_pkg.sv =====
// Shared constants, types and helper functions for the directed cycle detector.
// No dependencies; imported by dcd_engine and directed_cycle_detector_top.
`timescale 1ns / 1ps

package dcd_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ROW_W        = 32;
  localparam int IDX_W        = 5;   // vertex / row address
  localparam int VCNT_W       = 6;   // vertex_count register
  localparam int DEPTH_W      = 6;   // stack depth, holds 0..32
  localparam int NEXT_W       = 6;   // next column to scan, holds 0..32

  typedef logic [ROW_W-1:0] row_t;

  // one saved stack frame: vertex and the column to resume at
  typedef struct packed {
    logic [IDX_W-1:0]  vertex;
    logic [NEXT_W-1:0] next;
  } stack_entry_t;

  // engine status seen by the top level
  typedef struct packed {
    logic idle;
    logic done;
    logic found;
  } dcd_status_t;

  // lowest set bit; MSB of the result flags an empty vector
  function automatic logic [IDX_W:0] first_set(input row_t v);
    logic [IDX_W:0] r;
    r = {1'b1, {IDX_W{1'b0}}};
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (v[k]) begin
        r = {1'b0, IDX_W'(k)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/dcd_engine.sv =====
// Search engine: adjacency row memory, DFS stack memory, colour vectors and sequencer.
// Depends on dcd_pkg.
`timescale 1ns / 1ps

module dcd_engine import dcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_en,
  input  logic [IDX_W-1:0]  load_index,
  input  row_t              load_bits,
  input  logic              start,
  input  logic [VCNT_W-1:0] vertex_count,
  input  logic              result_take,
  output dcd_status_t       status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state;
  row_t               grey;
  row_t               black;
  logic [IDX_W-1:0]   top_vertex;
  logic [NEXT_W-1:0]  top_next;
  logic [DEPTH_W-1:0] depth;
  logic               found;

  row_t               adj_mem [MAX_VERTICES];
  row_t               adj_q;
  stack_entry_t       stack_mem [MAX_VERTICES];
  stack_entry_t       stack_q;

  logic               adj_rd_en;
  logic [IDX_W-1:0]   adj_rd_addr;
  logic               stk_wr_en;
  logic [IDX_W-1:0]   stk_wr_addr;
  stack_entry_t       stk_wr_data;
  logic               stk_rd_en;
  logic [IDX_W-1:0]   stk_rd_addr;

  logic [VCNT_W-1:0]  n_used;
  row_t               n_mask;
  row_t               ge_mask;
  row_t               white;
  row_t               cand;
  logic [IDX_W:0]     wsel;
  logic [IDX_W:0]     csel;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;
  logic [NEXT_W-1:0]  resume_col;

  assign n_used = (vertex_count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                         : vertex_count;

  always_comb begin
    for (int k = 0; k < ROW_W; k++) begin
      n_mask[k]  = (VCNT_W'(k) < n_used);
      ge_mask[k] = (NEXT_W'(k) >= top_next);
    end
  end

  assign white      = ~(grey | black) & n_mask;
  assign wsel       = first_set(white);
  // black targets are finished; the first remaining edge decides: grey is a cycle,
  // white is a push
  assign cand       = adj_q & ge_mask & n_mask & ~black;
  assign csel       = first_set(cand);
  assign depth_m1   = depth - DEPTH_W'(1);
  assign depth_m2   = depth - DEPTH_W'(2);
  assign resume_col = {1'b0, csel[IDX_W-1:0]} + NEXT_W'(1);

  // memory port control; the top frame lives in registers, so pushes and pops
  // never touch the same stack entry in one cycle
  always_comb begin
    adj_rd_en   = 1'b0;
    adj_rd_addr = '0;
    stk_wr_en   = 1'b0;
    stk_wr_addr = depth_m1[IDX_W-1:0];
    stk_wr_data = '{vertex: top_vertex, next: resume_col};
    stk_rd_en   = 1'b0;
    stk_rd_addr = depth_m2[IDX_W-1:0];
    unique case (state)
      S_START: begin
        if (!wsel[IDX_W]) begin
          adj_rd_en   = 1'b1;
          adj_rd_addr = wsel[IDX_W-1:0];
        end
      end
      S_SCAN: begin
        if (!csel[IDX_W]) begin
          if (!grey[csel[IDX_W-1:0]]) begin
            adj_rd_en   = 1'b1;
            adj_rd_addr = csel[IDX_W-1:0];
            stk_wr_en   = 1'b1;
          end
        end else if (depth != DEPTH_W'(1)) begin
          stk_rd_en = 1'b1;
        end
      end
      S_POP: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = stack_q.vertex;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      adj_mem[load_index] <= load_bits;
    end
    if (adj_rd_en) begin
      adj_q <= adj_mem[adj_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stack_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (stk_rd_en) begin
      stack_q <= stack_mem[stk_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
      found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            grey  <= '0;
            black <= '0;
            state <= S_START;
          end
        end
        S_START: begin
          if (wsel[IDX_W]) begin
            found <= 1'b0;
            state <= S_DONE;
          end else begin
            grey[wsel[IDX_W-1:0]] <= 1'b1;
            top_vertex <= wsel[IDX_W-1:0];
            top_next   <= '0;
            depth      <= DEPTH_W'(1);
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!csel[IDX_W]) begin
            if (grey[csel[IDX_W-1:0]]) begin
              found <= 1'b1;
              state <= S_DONE;
            end else begin
              grey[csel[IDX_W-1:0]] <= 1'b1;
              top_vertex <= csel[IDX_W-1:0];
              top_next   <= '0;
              depth      <= depth + DEPTH_W'(1);
            end
          end else begin
            black[top_vertex] <= 1'b1;
            grey[top_vertex]  <= 1'b0;
            depth             <= depth_m1;
            state             <= (depth == DEPTH_W'(1)) ? S_START : S_POP;
          end
        end
        S_POP: begin
          top_vertex <= stack_q.vertex;
          top_next   <= stack_q.next;
          state      <= S_SCAN;
        end
        S_DONE: begin
          if (result_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status = '{idle: (state == S_IDLE), done: (state == S_DONE), found: found};

endmodule

// ===== rtl/core/directed_cycle_detector_top.sv =====
// Top level of the directed cycle detector: config register, input handshake,
// result register. Depends on dcd_pkg and dcd_engine.
`timescale 1ns / 1ps

// Adjacency rows are taken one per cycle while the block is idle; a row with
// last_row set starts a depth-first search over vertices below vertex_count
// (clamped to 32) and produces one has_cycle result. Pushes and edge decisions
// are made in the scan state; a pop must read the stack memory and then the
// adjacency memory (both synchronous reads). The result register loads from the
// finished search once it is free. Input is not taken during a search. A
// finished result waits in the output register while new rows load.
module directed_cycle_detector_top import dcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  row_index,
  input  row_t              row_bits,
  input  logic              last_row,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_cycle
);

  logic [VCNT_W-1:0] vertex_count;
  logic              in_xfer;
  logic              result_take;
  dcd_status_t       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  assign in_ready    = status.idle;
  assign in_xfer     = in_valid & in_ready;
  assign result_take = status.done & (~out_valid | out_ready);

  dcd_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .load_en      (in_xfer),
    .load_index   (row_index),
    .load_bits    (row_bits),
    .start        (in_xfer & last_row),
    .vertex_count (vertex_count),
    .result_take  (result_take),
    .status       (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      has_cycle <= status.found;
    end
  end

endmodule
